/* hdl/pmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants of the pendulum mode controller.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // Q16.16 angle constants
  localparam int PI_Q     = 205887;
  localparam int TWO_PI_Q = 411775;
  localparam int ONE_Q    = 65536;

  // width of a wrapped angle, signed, covers plus or minus pi
  localparam int ANG_W = 19;

  // entries in the front to back queue
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_SWING_GAIN     = 3'd0;
  localparam logic [2:0] CFG_SWING_LIMIT    = 3'd1;
  localparam logic [2:0] CFG_SWING_EXIT     = 3'd2;
  localparam logic [2:0] CFG_CATCH_EXIT     = 3'd3;
  localparam logic [2:0] CFG_STAB_EXIT      = 3'd4;
  localparam logic [2:0] CFG_CATCH_OFFSET   = 3'd5;
  localparam logic [2:0] CFG_CATCH_GAINS    = 3'd6;
  localparam logic [2:0] CFG_STAB_GAINS     = 3'd7;

  typedef enum logic [1:0] {
    MODE_SWING = 2'd0,
    MODE_CATCH = 2'd1,
    MODE_STAB  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WRAP,
    F_PUSH
  } fstate_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIV,
    B_SQ,
    B_KLO,
    B_KHI,
    B_ECALC,
    B_ELO,
    B_EHI,
    B_SWFIN,
    B_FB0,
    B_FB1,
    B_FB2,
    B_FB3,
    B_FBFIN
  } bstate_t;

  // one sample with its wrapped pendulum angle
  typedef struct packed {
    logic signed [31:0]      th;
    logic signed [31:0]      dth;
    logic signed [31:0]      ph;
    logic signed [31:0]      dph;
    logic signed [ANG_W-1:0] r;
  } item_t;

  typedef struct packed {
    logic        full;
    logic        empty;
  } qstat_t;

  typedef struct packed {
    logic [20:0]        swing_gain;
    logic [20:0]        swing_limit;
    logic [20:0]        swing_exit_angle;
    logic [20:0]        catch_exit_speed;
    logic [20:0]        stab_exit_angle;
    logic signed [22:0] catch_arm_offset;
    logic [63:0]        catch_gains;
    logic [63:0]        stab_gains;
  } cfg_t;

endpackage

/* hdl/pmc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_queue
// Short queue of classified samples between the front and back ends.
// ----------------------------------------------------------------------------
module pmc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pmc_pkg::item_t push_item,
  input  logic           pop,
  output pmc_pkg::item_t head_item,
  output pmc_pkg::qstat_t stat
);
  import pmc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t           mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // status
  assign stat.full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_item  = mem_r[rd_ptr_r];

  // advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hdl/pmc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_front
// Accepts a sample, wraps the pendulum angle by serial remainder and queues it.
// ----------------------------------------------------------------------------
module pmc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic signed [31:0] in_pendulum_angle,
  input  logic signed [31:0] in_pendulum_rate,
  input  logic signed [31:0] in_arm_angle,
  input  logic signed [31:0] in_arm_rate,
  input  pmc_pkg::qstat_t q_stat,
  output logic            q_push,
  output pmc_pkg::item_t  q_item
);
  import pmc_pkg::*;

  // remainder steps: quotient of a 32-bit value by two pi fits in 14 bits
  localparam int WRAP_STEPS = 14;
  localparam int KW = $clog2(WRAP_STEPS);

  fstate_t            state_r, state_nxt;
  logic signed [31:0] th_r, dth_r, ph_r, dph_r;
  logic [31:0]        x_r;
  logic [KW-1:0]      k_r;
  logic               neg_r;

  logic [31:0]        mag;
  logic [31:0]        dsh;
  logic [32:0]        sub;
  logic signed [19:0] rw;
  logic signed [19:0] rs;
  logic               accept;

  assign accept = (state_r == F_IDLE) && in_valid;
  assign mag    = in_pendulum_angle[31] ? 32'(-in_pendulum_angle) : 32'(in_pendulum_angle);
  assign dsh    = 32'(TWO_PI_Q) << k_r;
  assign sub    = {1'b0, x_r} - {1'b0, dsh};

  // wrapped angle from the final remainder
  assign rw = $signed({1'b0, x_r[18:0]}) - 20'sd205887;
  assign rs = neg_r ? -rw : rw;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_WRAP;
      end
      F_WRAP: begin
        if (k_r == '0) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    q_push   = 1'b0;
    case (state_r)
      F_IDLE:  in_stall = 1'b0;
      F_WRAP:  in_stall = 1'b1;
      F_PUSH:  q_push   = !q_stat.full;
      default: in_stall = 1'b1;
    endcase
  end

  assign q_item.th  = th_r;
  assign q_item.dth = dth_r;
  assign q_item.ph  = ph_r;
  assign q_item.dph = dph_r;
  assign q_item.r   = rs[ANG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // load a transfer, then subtract shifted two pi one bit per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      th_r  <= in_pendulum_angle;
      dth_r <= in_pendulum_rate;
      ph_r  <= in_arm_angle;
      dph_r <= in_arm_rate;
      neg_r <= in_pendulum_angle[31];
      x_r   <= mag + 32'(PI_Q);
      k_r   <= KW'(WRAP_STEPS - 1);
    end else if (state_r == F_WRAP) begin
      if (!sub[32]) x_r <= sub[31:0];
      if (k_r != '0) k_r <= k_r - 1'b1;
    end
  end

endmodule

/* hdl/pmc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_back
// Computes the drive of one queued sample on a shared multiplier, applies the
// exit test of the current mode and holds the result register.
// ----------------------------------------------------------------------------
module pmc_back #(
  parameter int INV_W0_SQUARED  = 1651,
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pmc_pkg::cfg_t      cfg,
  input  pmc_pkg::qstat_t    q_stat,
  input  pmc_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic [1:0]         out_mode_used
);
  import pmc_pkg::*;

  localparam int TAB_N = COS_TABLE_DEPTH / 2 + 1;
  localparam int AW    = $clog2(TAB_N);
  localparam int KW    = $clog2(AW);
  localparam int NW    = 20 + $clog2(COS_TABLE_DEPTH + 1);
  localparam int INV_W = $clog2(INV_W0_SQUARED + 1);

  // cos table entry: Q30 Taylor series folded about half pi, in Q16.16
  function automatic logic signed [17:0] cos_entry(input int a);
    longint t;
    longint u;
    longint u2;
    longint q;
    longint one;
    logic   neg;
    one = longint'(1) <<< 30;
    neg = 1'b0;
    t   = (longint'(a) * TWO_PI_Q + COS_TABLE_DEPTH / 2) / COS_TABLE_DEPTH;
    if (t > PI_Q) t = PI_Q;
    if (t > 102944) begin
      t   = PI_Q - t;
      neg = 1'b1;
    end
    u  = t * 16384;
    u2 = (u * u) >>> 30;
    q  = one - u2 / 90;
    q  = one - ((u2 * q) >>> 30) / 56;
    q  = one - ((u2 * q) >>> 30) / 30;
    q  = one - ((u2 * q) >>> 30) / 12;
    q  = one - ((u2 * q) >>> 30) / 2;
    if (q < 0) q = 0;
    q = (q + 8192) >>> 14;
    return neg ? 18'(-q) : 18'(q);
  endfunction

  logic signed [17:0] cos_rom [TAB_N];

  bstate_t            st_r, st_nxt;
  item_t              it_r;
  logic [NW-1:0]      n_r;
  logic [AW-1:0]      q_r;
  logic [KW-1:0]      k_r;
  logic signed [17:0] cos_r;
  logic signed [65:0] prod_r;
  logic signed [63:0] acc_r;
  logic [23:0]        sqhi_r;
  logic [40:0]        em_r;
  logic               eneg_r, ezero_r;
  mode_t              mode_r;
  logic signed [31:0] latch_r;
  logic               out_valid_r;
  logic signed [31:0] out_drive_r;
  logic [1:0]         out_mode_r;

  logic signed [32:0] mul_a, mul_b;
  logic               out_free;
  logic               fin_load;
  logic [31:0]        dm;
  logic [31:0]        th_mag;
  logic [31:0]        dph_mag;
  logic [ANG_W-1:0]   r_mag;
  logic [ANG_W-1:0]   head_r_mag;
  logic [63:0]        g;
  logic signed [32:0] arm;
  logic [NW-1:0]      dsh;
  logic [63:0]        ksum;
  logic [46:0]        kin;
  logic signed [48:0] e;
  logic [48:0]        e_mag;
  logic [63:0]        msum;
  logic [47:0]        m;
  logic [20:0]        sw_mag;
  logic signed [31:0] sw_drive;
  logic signed [63:0] fb_sum;
  logic signed [63:0] fb_neg;
  logic signed [63:0] fb_y;
  logic signed [31:0] fb_drive;
  mode_t              mode_nxt;
  logic               latch_en;

  // constant cos table over a half turn
  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_rom
    assign cos_rom[gi] = cos_entry(gi);
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign dm         = it_r.dth[31] ? 32'(-it_r.dth) : 32'(it_r.dth);
  assign th_mag     = it_r.th[31] ? 32'(-it_r.th) : 32'(it_r.th);
  assign dph_mag    = it_r.dph[31] ? 32'(-it_r.dph) : 32'(it_r.dph);
  assign r_mag      = it_r.r[ANG_W-1] ? ANG_W'(-it_r.r) : ANG_W'(it_r.r);
  assign head_r_mag = q_item.r[ANG_W-1] ? ANG_W'(-q_item.r) : ANG_W'(q_item.r);
  assign g          = (mode_r == MODE_CATCH) ? cfg.catch_gains : cfg.stab_gains;
  assign arm        = (mode_r == MODE_CATCH)
                      ? 33'(it_r.ph) - 33'(cfg.catch_arm_offset)
                      : 33'(it_r.ph) - 33'(latch_r);
  assign dsh        = NW'(TWO_PI_Q) << k_r;

  // energy from kinetic term and cos
  assign ksum  = acc_r[63:0] + {prod_r[40:0], 23'b0};
  assign kin   = ksum[63:17];
  assign e     = $signed({2'b0, kin}) + 49'(cos_r) - 49'sd65536;
  assign e_mag = e[48] ? 49'(-e) : 49'(e);

  // limited swing-up drive
  assign msum     = 64'(acc_r) + {prod_r[42:0], 21'b0};
  assign m        = msum[63:16];
  assign sw_mag   = (m > 48'(cfg.swing_limit)) ? cfg.swing_limit : m[20:0];
  assign sw_drive = (ezero_r || (it_r.dth == '0) || (cos_r == '0)) ? 32'sd0
                    : ((eneg_r ^ it_r.dth[31] ^ cos_r[17]) ? -32'(sw_mag) : 32'(sw_mag));

  // feedback: negate, round to Q16.16, saturate
  assign fb_sum   = acc_r + prod_r[63:0];
  assign fb_neg   = -fb_sum + 64'sd8192;
  assign fb_y     = fb_neg >>> 14;
  assign fb_drive = (fb_y > 64'sd2147483647) ? 32'sh7fffffff
                    : ((fb_y < -64'sd2147483648) ? 32'sh80000000 : fb_y[31:0]);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          if (mode_r == MODE_CATCH || mode_r == MODE_STAB) st_nxt = B_FB0;
          else st_nxt = B_DIV;
        end
      end
      B_DIV:   if (k_r == '0) st_nxt = B_SQ;
      B_SQ:    st_nxt = B_KLO;
      B_KLO:   st_nxt = B_KHI;
      B_KHI:   st_nxt = B_ECALC;
      B_ECALC: st_nxt = B_ELO;
      B_ELO:   st_nxt = B_EHI;
      B_EHI:   st_nxt = B_SWFIN;
      B_SWFIN: if (out_free) st_nxt = B_IDLE;
      B_FB0:   st_nxt = B_FB1;
      B_FB1:   st_nxt = B_FB2;
      B_FB2:   st_nxt = B_FB3;
      B_FB3:   st_nxt = B_FBFIN;
      B_FBFIN: if (out_free) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // outputs: multiplier operands, queue pop, result load, mode update
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    q_pop    = 1'b0;
    fin_load = 1'b0;
    mode_nxt = mode_r;
    latch_en = 1'b0;
    case (st_r)
      B_IDLE: q_pop = !q_stat.empty;
      B_SQ: begin
        mul_a = {1'b0, dm};
        mul_b = {1'b0, dm};
      end
      B_KLO: begin
        mul_a = 33'({1'b0, prod_r[38:16]});
        mul_b = 33'({1'b0, INV_W'(INV_W0_SQUARED)});
      end
      B_KHI: begin
        mul_a = 33'({1'b0, sqhi_r});
        mul_b = 33'({1'b0, INV_W'(INV_W0_SQUARED)});
      end
      B_ELO: begin
        mul_a = 33'({1'b0, cfg.swing_gain});
        mul_b = 33'({1'b0, em_r[20:0]});
      end
      B_EHI: begin
        mul_a = 33'({1'b0, cfg.swing_gain});
        mul_b = 33'({1'b0, em_r[40:21]});
      end
      B_SWFIN: begin
        // hold the upper product while the result register is stalled
        mul_a    = 33'({1'b0, cfg.swing_gain});
        mul_b    = 33'({1'b0, em_r[40:21]});
        fin_load = out_free;
        if (out_free && (th_mag < 32'(cfg.swing_exit_angle))) mode_nxt = MODE_CATCH;
      end
      B_FB0: begin
        mul_a = 33'(it_r.r);
        mul_b = 33'($signed(g[15:0]));
      end
      B_FB1: begin
        mul_a = 33'(it_r.dth);
        mul_b = 33'($signed(g[31:16]));
      end
      B_FB2: begin
        mul_a = arm;
        mul_b = 33'($signed(g[47:32]));
      end
      B_FB3: begin
        mul_a = 33'(it_r.dph);
        mul_b = 33'($signed(g[63:48]));
      end
      B_FBFIN: begin
        // hold the last term while the result register is stalled
        mul_a    = 33'(it_r.dph);
        mul_b    = 33'($signed(g[63:48]));
        fin_load = out_free;
        if (out_free) begin
          if (mode_r == MODE_CATCH) begin
            if (dph_mag < 32'(cfg.catch_exit_speed)) begin
              mode_nxt = MODE_STAB;
              latch_en = 1'b1;
            end
          end else if (21'(r_mag) > cfg.stab_exit_angle) begin
            mode_nxt = MODE_SWING;
          end
        end
      end
      default: mul_a = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      mode_r      <= MODE_SWING;
      latch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      mode_r <= mode_nxt;
      if (latch_en) latch_r <= it_r.ph;
      if (fin_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // shared multiplier and table read
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    cos_r  <= cos_rom[q_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          it_r <= q_item;
          n_r  <= NW'(head_r_mag) * NW'(COS_TABLE_DEPTH) + NW'(TWO_PI_Q / 2);
          q_r  <= '0;
          k_r  <= KW'(AW - 1);
        end
      end
      B_DIV: begin
        if (n_r >= dsh) begin
          n_r      <= n_r - dsh;
          q_r[k_r] <= 1'b1;
        end
        if (k_r != '0) k_r <= k_r - 1'b1;
      end
      B_KLO: sqhi_r <= prod_r[62:39];
      B_KHI: acc_r <= prod_r[63:0];
      B_ECALC: begin
        em_r    <= (e_mag > 49'h100_0000_0000) ? 41'h100_0000_0000 : e_mag[40:0];
        eneg_r  <= e[48];
        ezero_r <= (e == '0);
      end
      B_EHI: acc_r <= prod_r[63:0];
      B_FB1: acc_r <= prod_r[63:0];
      B_FB2: acc_r <= acc_r + prod_r[63:0];
      B_FB3: acc_r <= acc_r + prod_r[63:0];
      default: acc_r <= acc_r;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_load) begin
      if (st_r == B_SWFIN) begin
        out_drive_r <= sw_drive;
        out_mode_r  <= MODE_SWING;
      end else begin
        out_drive_r <= fb_drive;
        out_mode_r  <= mode_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_mode_used = out_mode_r;

endmodule

/* hdl/pendulum_mode_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pendulum_mode_controller_top
// Pendulum mode controller: swing-up, catch and stabilize drive per sample.
//
// One sample (pendulum angle and rate, arm angle and rate, Q16.16) is taken
// on the in_ channel when in_valid is high and in_stall low; one drive and
// the mode it was computed in leave on the out_ channel the same way.
// The front end wraps the pendulum angle with a 14-step serial remainder and
// takes a new sample only once the last one is queued. A two-entry queue
// feeds the back end, which runs one shared 33x33 multiplier: feedback items
// step through the gain products of angle, rate, arm and arm rate; swing-up
// items run a serial divide for the cos table address, then the rate square,
// kinetic and gain-times-energy products. The cfg_ port writes one
// register per cycle with cfg_we; write only when idle. Reset returns to
// swing-up, clears the latched arm angle and loads the register defaults.
// While out_stall is high the result holds, the back end waits and the queue
// then the input channel fill and stall.
// ----------------------------------------------------------------------------
module pendulum_mode_controller_top #(
  parameter int INV_W0_SQUARED  = 1651,
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pendulum_angle,
  input  logic signed [31:0] in_pendulum_rate,
  input  logic signed [31:0] in_arm_angle,
  input  logic signed [31:0] in_arm_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic [1:0]         out_mode_used,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import pmc_pkg::*;

  cfg_t   cfg_r;
  item_t  push_item;
  item_t  head_item;
  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swing_gain       <= 21'd32768;
      cfg_r.swing_limit      <= 21'd32768;
      cfg_r.swing_exit_angle <= 21'd6554;
      cfg_r.catch_exit_speed <= 21'd3277;
      cfg_r.stab_exit_angle  <= 21'd13107;
      cfg_r.catch_arm_offset <= -23'sd459569;
      cfg_r.catch_gains      <= '0;
      cfg_r.stab_gains       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWING_GAIN:   cfg_r.swing_gain       <= cfg_data[20:0];
        CFG_SWING_LIMIT:  cfg_r.swing_limit      <= cfg_data[20:0];
        CFG_SWING_EXIT:   cfg_r.swing_exit_angle <= cfg_data[20:0];
        CFG_CATCH_EXIT:   cfg_r.catch_exit_speed <= cfg_data[20:0];
        CFG_STAB_EXIT:    cfg_r.stab_exit_angle  <= cfg_data[20:0];
        CFG_CATCH_OFFSET: cfg_r.catch_arm_offset <= cfg_data[22:0];
        CFG_CATCH_GAINS:  cfg_r.catch_gains      <= cfg_data;
        CFG_STAB_GAINS:   cfg_r.stab_gains       <= cfg_data;
        default:          cfg_r.catch_gains      <= cfg_r.catch_gains;
      endcase
    end
  end

  pmc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pendulum_angle (in_pendulum_angle),
    .in_pendulum_rate  (in_pendulum_rate),
    .in_arm_angle      (in_arm_angle),
    .in_arm_rate       (in_arm_rate),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  pmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  pmc_back #(
    .INV_W0_SQUARED  (INV_W0_SQUARED),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_stat        (q_stat),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive     (out_drive),
    .out_mode_used (out_mode_used)
  );

endmodule

/* hdl/pmc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_checker
// Port-level checks of the pendulum mode controller, bound to the top level.
// ----------------------------------------------------------------------------
module pmc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] in_pendulum_angle,
  input logic signed [31:0] in_pendulum_rate,
  input logic signed [31:0] in_arm_angle,
  input logic signed [31:0] in_arm_rate,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_drive,
  input logic [1:0]         out_mode_used,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [63:0]        cfg_data
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the front end is busy right after taking a transfer
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while wrapping");

  // only the three defined modes are reported
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mode_used != 2'd3)
    else $error("undefined mode reported");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive) && $stable(out_mode_used))
    else $error("stalled result changed");

endmodule

bind pendulum_mode_controller_top pmc_checker u_pmc_checker (.*);
